/* sv/olt_pkg.sv */
// Shared types and codes for the ordered list table.
// Used by olt_ctrl and ordered_list_table_core; no dependencies.
`timescale 1ns / 1ps

package olt_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int DATA_W       = 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_LOCATE = 3'd3;
	localparam logic [2:0] CMD_PRED   = 3'd4;
	localparam logic [2:0] CMD_SUCC   = 3'd5;
	localparam logic [2:0] CMD_CLEAR  = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_NONEIGH  = 2'd3;

	typedef struct packed {
		logic [2:0]               cmd;
		logic [7:0]               position;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] out_value;
		logic [7:0]               found_position;
		logic [7:0]               list_count;
	} out_word_t;

endpackage

/* sv/ordered_list_table_core.sv */
// Ordered list table: fixed-capacity list of signed words in one RAM.
// Errors and clear touch no RAM; insert and delete walk the words from the
// position to the list end, read fetches one word, locate/pred/succ scan from
// the head. One word at a time: the next is taken once the sequencer is idle.
// Reset clears the length and handshakes; RAM contents are left as they are.
// Depends on olt_pkg, olt_ctrl, olt_ram.
`timescale 1ns / 1ps

module ordered_list_table_core #(
	parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  olt_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output olt_pkg::out_word_t out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                       idle, res_valid, res_ready;
	olt_pkg::out_word_t         res;
	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [olt_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
	logic                       out_valid_q;
	olt_pkg::out_word_t         out_data_q;

	assign in_ready  = idle;
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	olt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.cmd_word  (in_data),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	olt_ram #(.WIDTH(olt_pkg::DATA_W), .DEPTH(CAPACITY)) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register parts result delivery from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/olt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module olt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/olt_ctrl.sv */
// Sequencer for the ordered list table: decodes a command, then walks the
// entry RAM (shift up, shift down, scan) one address per cycle.
// Depends on olt_pkg; drives an olt_ram instance through its port signals.
`timescale 1ns / 1ps

module olt_ctrl #(
	parameter int CAPACITY = olt_pkg::CAPACITY_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  olt_pkg::in_word_t         cmd_word,
	output logic                      idle,
	output logic                      res_valid,
	input  logic                      res_ready,
	output olt_pkg::out_word_t        res,
	output logic                      ram_we,
	output logic [AW-1:0]             ram_waddr,
	output logic [olt_pkg::DATA_W-1:0] ram_wdata,
	output logic                      ram_re,
	output logic [AW-1:0]             ram_raddr,
	input  logic [olt_pkg::DATA_W-1:0] ram_rdata
);

	localparam int PW = ((LW > 8) ? LW : 8) + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SHUP = 5'b00010,
		S_SHDN = 5'b00100,
		S_SCAN = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [2:0]                 cmd_q;
	logic [AW-1:0]              pos_q;    // target address, position - 1
	logic [olt_pkg::DATA_W-1:0] val_q;
	logic [LW-1:0]              len_q;
	logic [AW-1:0]              cnt_q;    // next read address
	logic [LW-1:0]              rem_q;    // reads still to issue
	logic                       pend_s1;
	logic [AW-1:0]              paddr_s1;
	logic                       found_q;
	logic [olt_pkg::DATA_W-1:0] prev_q;
	logic [1:0]                 status_q;
	logic [olt_pkg::DATA_W-1:0] oval_q;
	logic [7:0]                 fpos_q;

	logic [PW-1:0] pos_w, len_w, cap_w, hit_pos;
	logic          pos_zero, hit;

	assign pos_w    = PW'(cmd_word.position);
	assign len_w    = PW'(len_q);
	assign cap_w    = PW'(CAPACITY);
	assign pos_zero = (cmd_word.position == 8'd0);
	assign hit_pos  = PW'(paddr_s1) + PW'(1);
	assign hit      = pend_s1 && (ram_rdata == val_q);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status: status_q, out_value: $signed(oval_q),
	                     found_position: fpos_q, list_count: 8'(len_q)};

	// read issue: one address per cycle while reads remain and no successor match is held
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		if (rem_q != '0) begin
			if (state_q == S_SHUP || state_q == S_SHDN) begin
				ram_re = 1'b1;
			end else if (state_q == S_SCAN && !found_q) begin
				ram_re = 1'b1;
			end
		end
	end

	// write back: moved word lands one slot over from where it was read; insert then writes the new value at the target
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ram_rdata;
		if (state_q == S_SHUP) begin
			if (pend_s1) begin
				ram_we    = 1'b1;
				ram_waddr = AW'(paddr_s1 + AW'(1));
			end else if (rem_q == '0) begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
		end else if (state_q == S_SHDN) begin
			if (pend_s1 && cmd_q == olt_pkg::CMD_DELETE && paddr_s1 != pos_q) begin
				ram_we    = 1'b1;
				ram_waddr = AW'(paddr_s1 - AW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			pend_s1 <= 1'b0;
			rem_q   <= '0;
			found_q <= 1'b0;
		end else begin
			pend_s1  <= ram_re;
			paddr_s1 <= cnt_q;
			if (ram_re) begin
				cnt_q <= (state_q == S_SHUP) ? AW'(cnt_q - AW'(1)) : AW'(cnt_q + AW'(1));
				rem_q <= LW'(rem_q - LW'(1));
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd_word.cmd;
						val_q    <= cmd_word.value;
						pos_q    <= AW'(pos_w - PW'(1));
						oval_q   <= '0;
						fpos_q   <= '0;
						status_q <= olt_pkg::ST_OK;
						found_q  <= 1'b0;
						unique case (cmd_word.cmd)
							olt_pkg::CMD_INSERT: begin
								if (len_w >= cap_w || pos_zero || pos_w > len_w + PW'(1)) begin
									status_q <= olt_pkg::ST_BAD;
									state_q  <= S_DONE;
								end else begin
									cnt_q   <= AW'(len_w - PW'(1));
									rem_q   <= LW'(len_w - pos_w + PW'(1));
									state_q <= S_SHUP;
								end
							end
							olt_pkg::CMD_DELETE, olt_pkg::CMD_READ: begin
								if (pos_zero || pos_w > len_w) begin
									status_q <= olt_pkg::ST_BAD;
									state_q  <= S_DONE;
								end else begin
									cnt_q   <= AW'(pos_w - PW'(1));
									rem_q   <= (cmd_word.cmd == olt_pkg::CMD_DELETE) ?
									           LW'(len_w - pos_w + PW'(1)) : LW'(1);
									state_q <= S_SHDN;
								end
							end
							olt_pkg::CMD_LOCATE, olt_pkg::CMD_PRED, olt_pkg::CMD_SUCC: begin
								cnt_q   <= '0;
								rem_q   <= len_q;
								state_q <= S_SCAN;
							end
							olt_pkg::CMD_CLEAR: begin
								len_q   <= '0;
								state_q <= S_DONE;
							end
							default: begin
								status_q <= olt_pkg::ST_BAD;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SHUP: begin
					if (!pend_s1 && rem_q == '0) begin
						len_q   <= LW'(len_q + LW'(1));
						state_q <= S_DONE;
					end
				end
				S_SHDN: begin
					if (pend_s1 && paddr_s1 == pos_q) begin
						oval_q <= ram_rdata;
					end
					if (!pend_s1 && rem_q == '0) begin
						if (cmd_q == olt_pkg::CMD_DELETE) begin
							len_q <= LW'(len_q - LW'(1));
						end
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					priority if (pend_s1 && found_q) begin
						// word after the match, successor only
						oval_q  <= ram_rdata;
						state_q <= S_DONE;
					end else if (hit) begin
						fpos_q <= 8'(hit_pos);
						if (cmd_q == olt_pkg::CMD_PRED) begin
							if (paddr_s1 == '0) status_q <= olt_pkg::ST_NONEIGH;
							else oval_q <= prev_q;
							state_q <= S_DONE;
						end else if (cmd_q == olt_pkg::CMD_SUCC) begin
							if (hit_pos == len_w) begin
								status_q <= olt_pkg::ST_NONEIGH;
								state_q  <= S_DONE;
							end else begin
								found_q <= 1'b1;
							end
						end else begin
							state_q <= S_DONE;
						end
					end else if (pend_s1) begin
						prev_q <= ram_rdata;
					end else if (rem_q == '0) begin
						status_q <= olt_pkg::ST_NOTFOUND;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					found_q <= 1'b0;
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/tb_ordered_list_table_core.sv */
// Testbench for ordered_list_table_core: directed and random list commands
// checked word by word against a behavioral list predictor.
// Depends on olt_pkg and the ordered_list_table_core RTL.
`timescale 1ns / 1ps

module tb_ordered_list_table_core;

	localparam int         CAP        = olt_pkg::CAPACITY_DEF;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int         LIMIT      = 1000000;
	localparam int         DRAIN      = CAP + 22;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	olt_pkg::in_word_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	olt_pkg::out_word_t out_data;

	// predictor state
	logic signed [olt_pkg::DATA_W-1:0] shadow_mem [CAP];
	int                                shadow_len = 0;
	olt_pkg::out_word_t                pending_results [$];

	bit idle_en   = 1'b1;
	int err_cnt   = 0;
	int checked   = 0;
	int full_hits = 0;
	int cmd_seen [8];

	ordered_list_table_core #(
		.CAPACITY(CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one command to the shadow list and returns the word it should give.
	function automatic olt_pkg::out_word_t predict_list_op(input olt_pkg::in_word_t w);
		olt_pkg::out_word_t r;
		int                 p;
		int                 k;
		int                 m;
		r = '0;
		r.status = olt_pkg::ST_OK;
		p = int'(w.position);
		case (w.cmd)
			olt_pkg::CMD_INSERT: begin
				if (shadow_len >= CAP) begin
					r.status = olt_pkg::ST_BAD;
					full_hits++;
				end else if (p < 1 || p > shadow_len + 1) begin
					r.status = olt_pkg::ST_BAD;
				end else begin
					for (k = shadow_len; k > p - 1; k--)
						shadow_mem[k] = shadow_mem[k-1];
					shadow_mem[p-1] = w.value;
					shadow_len++;
				end
			end
			olt_pkg::CMD_DELETE: begin
				if (p < 1 || p > shadow_len) begin
					r.status = olt_pkg::ST_BAD;
				end else begin
					r.out_value = shadow_mem[p-1];
					for (k = p - 1; k + 1 < shadow_len; k++)
						shadow_mem[k] = shadow_mem[k+1];
					shadow_len--;
				end
			end
			olt_pkg::CMD_READ: begin
				if (p < 1 || p > shadow_len)
					r.status = olt_pkg::ST_BAD;
				else
					r.out_value = shadow_mem[p-1];
			end
			olt_pkg::CMD_LOCATE, olt_pkg::CMD_PRED, olt_pkg::CMD_SUCC: begin
				m = 0;
				while (m < shadow_len && shadow_mem[m] != w.value)
					m++;
				if (m >= shadow_len) begin
					r.status = olt_pkg::ST_NOTFOUND;
				end else begin
					r.found_position = 8'(m + 1);
					if (w.cmd == olt_pkg::CMD_PRED) begin
						if (m == 0)
							r.status = olt_pkg::ST_NONEIGH;
						else
							r.out_value = shadow_mem[m-1];
					end else if (w.cmd == olt_pkg::CMD_SUCC) begin
						if (m + 1 >= shadow_len)
							r.status = olt_pkg::ST_NONEIGH;
						else
							r.out_value = shadow_mem[m+1];
					end
				end
			end
			olt_pkg::CMD_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
				r.status = olt_pkg::ST_BAD;
			end
		endcase
		r.list_count = 8'(shadow_len);
		return r;
	endfunction

	// Sends one word; an optional idle burst goes ahead of it.
	task automatic push_word(input olt_pkg::in_word_t w);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		cmd_seen[w.cmd]++;
		pending_results.push_back(predict_list_op(w));
	endtask

	task automatic op(input logic [2:0] cmd, input int pos, input logic signed [31:0] val);
		olt_pkg::in_word_t w;
		w.cmd      = cmd;
		w.position = 8'(pos);
		w.value    = val;
		push_word(w);
	endtask

	function automatic olt_pkg::in_word_t random_word(input int ins_pct, input int del_pct,
		input int clr_pct);
		olt_pkg::in_word_t w;
		int                r;
		int                hi;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			w.cmd = olt_pkg::CMD_INSERT;
		else if (r < ins_pct + del_pct)
			w.cmd = olt_pkg::CMD_DELETE;
		else if (r < ins_pct + del_pct + clr_pct)
			w.cmd = olt_pkg::CMD_CLEAR;
		else if (r < ins_pct + del_pct + clr_pct + 1)
			w.cmd = CMD_UNUSED;
		else begin
			case ($urandom_range(0, 3))
				0:       w.cmd = olt_pkg::CMD_READ;
				1:       w.cmd = olt_pkg::CMD_LOCATE;
				2:       w.cmd = olt_pkg::CMD_PRED;
				default: w.cmd = olt_pkg::CMD_SUCC;
			endcase
		end
		hi = (w.cmd == olt_pkg::CMD_INSERT) ? shadow_len + 1 : shadow_len;
		case ($urandom_range(0, 9))
			7:       w.position = 8'd0;
			8:       w.position = 8'(hi + 1);
			9:       w.position = 8'($urandom_range(0, 255));
			default: w.position = (hi > 0) ? 8'($urandom_range(1, hi)) : 8'd1;
		endcase
		r = $urandom_range(0, 9);
		if (r < 5 && shadow_len > 0)
			w.value = shadow_mem[$urandom_range(0, shadow_len - 1)];
		else if (r < 7)
			w.value = int'($urandom_range(0, 8)) - 4;
		else if (r == 7)
			w.value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		else
			w.value = $urandom;
		return w;
	endfunction

	// Result check and receiver stalls.
	always @(posedge clk) begin : result_check
		olt_pkg::out_word_t exp_w;
		int                 stall_left;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %p", $time, out_data);
				err_cnt++;
			end else begin
				exp_w = pending_results.pop_front();
				checked++;
				if (out_data.status !== exp_w.status) begin
					$display("%0t: status exp %0d got %0d", $time, exp_w.status,
						out_data.status);
					err_cnt++;
				end
				if (out_data.out_value !== exp_w.out_value) begin
					$display("%0t: out_value exp %0d got %0d", $time, exp_w.out_value,
						out_data.out_value);
					err_cnt++;
				end
				if (out_data.found_position !== exp_w.found_position) begin
					$display("%0t: found_position exp %0d got %0d", $time,
						exp_w.found_position, out_data.found_position);
					err_cnt++;
				end
				if (out_data.list_count !== exp_w.list_count) begin
					$display("%0t: list_count exp %0d got %0d", $time, exp_w.list_count,
						out_data.list_count);
					err_cnt++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Empty-list errors, edges of the value range, neighbors at both ends.
	task automatic test_directed_ops;
		op(olt_pkg::CMD_READ, 1, 0);
		op(olt_pkg::CMD_DELETE, 1, 0);
		op(olt_pkg::CMD_LOCATE, 0, 5);
		op(olt_pkg::CMD_INSERT, 0, 9);
		op(olt_pkg::CMD_INSERT, 2, 9);
		op(olt_pkg::CMD_INSERT, 1, 32'sh7fffffff);
		op(olt_pkg::CMD_INSERT, 1, 32'sh80000000);
		op(olt_pkg::CMD_INSERT, 3, 0);
		op(olt_pkg::CMD_INSERT, 2, -1);
		op(olt_pkg::CMD_READ, 1, 0);
		op(olt_pkg::CMD_READ, 4, 0);
		op(olt_pkg::CMD_READ, 5, 0);
		op(olt_pkg::CMD_PRED, 0, 32'sh80000000);
		op(olt_pkg::CMD_PRED, 0, 32'sh7fffffff);
		op(olt_pkg::CMD_SUCC, 0, 0);
		op(olt_pkg::CMD_SUCC, 0, 32'sh80000000);
		op(olt_pkg::CMD_LOCATE, 0, 0);
		op(olt_pkg::CMD_PRED, 0, 12345);
		op(olt_pkg::CMD_SUCC, 0, 12345);
		op(CMD_UNUSED, 255, -1);
		op(olt_pkg::CMD_DELETE, 255, 0);
		op(olt_pkg::CMD_DELETE, 2, 0);
		op(olt_pkg::CMD_DELETE, 3, 0);
		op(olt_pkg::CMD_CLEAR, 0, 0);
		op(olt_pkg::CMD_READ, 1, 0);
	endtask

	// Fill to capacity with duplicates, then hit the full and end-of-list cases.
	task automatic test_full_list;
		while (shadow_len < CAP)
			op(olt_pkg::CMD_INSERT, $urandom_range(1, shadow_len + 1),
				int'($urandom_range(0, 40)) - 20);
		op(olt_pkg::CMD_INSERT, 1, 1);
		op(olt_pkg::CMD_INSERT, CAP + 1, 1);
		op(olt_pkg::CMD_READ, CAP, 0);
		op(olt_pkg::CMD_READ, CAP + 1, 0);
		op(olt_pkg::CMD_LOCATE, 0, shadow_mem[CAP-1]);
		op(olt_pkg::CMD_SUCC, 0, shadow_mem[CAP/2]);
		op(olt_pkg::CMD_PRED, 0, shadow_mem[CAP-1]);
		op(olt_pkg::CMD_DELETE, CAP, 0);
		op(olt_pkg::CMD_DELETE, 1, 0);
		op(olt_pkg::CMD_CLEAR, 0, 0);
	endtask

	task automatic test_random_ops(input int n, input int ins_pct, input int del_pct,
		input int clr_pct);
		repeat (n)
			push_word(random_word(ins_pct, del_pct, clr_pct));
	endtask

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("%0t: timeout, %0d results still pending", $time, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_full_list();
		test_random_ops(200, 75, 5, 0);
		test_random_ops(220, 35, 30, 1);
		test_random_ops(100, 10, 60, 0);
		idle_en = 1'b0;
		test_random_ops(130, 40, 25, 1);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("Checked %0d result words; inserts into a full list: %0d", checked, full_hits);
		$display("Commands ins/del/rd/loc/pred/succ/clr/unused: %0d %0d %0d %0d %0d %0d %0d %0d",
			cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4], cmd_seen[5],
			cmd_seen[6], cmd_seen[7]);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
sv/olt_pkg.sv
sv/olt_ram.sv
sv/olt_ctrl.sv
sv/ordered_list_table_core.sv
dv/tb_ordered_list_table_core.sv
